FILE: rtl/lrle_pkg.sv
`timescale 1ns / 1ps
package lrle_pkg;
   localparam int ColorWidth = 8;
   localparam int CountWidth = 25;
   localparam int SumWidth   = 32;

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [SumWidth-1:0]   sum_red;
      logic [SumWidth-1:0]   sum_green;
      logic [SumWidth-1:0]   sum_blue;
      logic                  last;
   } group_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;
endpackage

FILE: rtl/lrle_front.sv
`timescale 1ns / 1ps
module lrle_front #(
   parameter int MAX_FRAME_PIXELS = 16777216
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [7:0]                         tolerance,
   input  logic                               in_valid,
   output logic                               in_stall,
   input  logic [7:0]                         red,
   input  logic [7:0]                         green,
   input  logic [7:0]                         blue,
   input  logic                               last_pixel,
   output logic                               q_push,
   output lrle_pkg::group_type                q_data,
   input  logic                               q_room2
);
   import lrle_pkg::*;

   logic                  run_open_ff, run_open_in;
   logic [23:0]           run_color_ff, run_color_in;
   logic                  group_open_ff, group_open_in;
   logic [23:0]           ref_ff, ref_in;
   logic [SumWidth-1:0]   sr_ff, sg_ff, sb_ff, sr_in, sg_in, sb_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   // A pixel that emits two groups pushes the second on the following cycle.
   logic                  pend_ff, pend_in;
   group_type             pend_data_ff, pend_data_in;

   logic [23:0] color;
   logic        fire, merge_ok, new_run, close, full;
   group_type   cur;

   function automatic logic near(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] t);
      logic [7:0] d;
      d = (a >= b) ? a - b : b - a;
      return d <= t;
   endfunction

   assign color    = {red, green, blue};
   assign in_stall = pend_ff || !q_room2;
   assign fire     = in_valid && !in_stall;
   assign merge_ok = near(red, ref_ff[23:16], tolerance) &&
                     near(green, ref_ff[15:8], tolerance) &&
                     near(blue, ref_ff[7:0], tolerance);
   assign new_run  = !(run_open_ff && color == run_color_ff);
   assign close    = new_run && group_open_ff && !merge_ok;
   assign full     = !close && group_open_ff &&
                     cnt_ff >= CountWidth'(MAX_FRAME_PIXELS);
   assign cur      = '{count: cnt_ff, sum_red: sr_ff, sum_green: sg_ff,
                       sum_blue: sb_ff, last: 1'b0};

   always_comb begin
      logic restart;
      run_open_in   = run_open_ff;
      run_color_in  = run_color_ff;
      group_open_in = group_open_ff;
      ref_in        = ref_ff;
      sr_in = sr_ff; sg_in = sg_ff; sb_in = sb_ff; cnt_in = cnt_ff;
      pend_in       = 1'b0;
      pend_data_in  = pend_data_ff;
      q_push        = pend_ff;
      q_data        = pend_data_ff;
      restart       = close || full || (new_run && !group_open_ff);
      if (fire) begin
         run_open_in  = 1'b1;
         run_color_in = color;
         group_open_in = 1'b1;
         if (restart) begin
            if (new_run || full) ref_in = color;
            sr_in = SumWidth'(red); sg_in = SumWidth'(green);
            sb_in = SumWidth'(blue); cnt_in = CountWidth'(1);
         end else begin
            sr_in = sr_ff + SumWidth'(red); sg_in = sg_ff + SumWidth'(green);
            sb_in = sb_ff + SumWidth'(blue); cnt_in = cnt_ff + 1'b1;
         end
         if (close || full) begin
            q_push = 1'b1;
            q_data = cur;
            if (last_pixel) begin
               pend_in = 1'b1;
               pend_data_in = '{count: cnt_in, sum_red: sr_in, sum_green: sg_in,
                                sum_blue: sb_in, last: 1'b1};
            end
         end else if (last_pixel) begin
            q_push = 1'b1;
            q_data = '{count: cnt_in, sum_red: sr_in, sum_green: sg_in,
                       sum_blue: sb_in, last: 1'b1};
         end
         if (last_pixel) begin
            run_open_in = 1'b0; run_color_in = '0; group_open_in = 1'b0;
            ref_in = '0; sr_in = '0; sg_in = '0; sb_in = '0; cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0; run_color_ff <= '0; group_open_ff <= 1'b0;
         ref_ff <= '0; sr_ff <= '0; sg_ff <= '0; sb_ff <= '0; cnt_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         run_open_ff <= run_open_in; run_color_ff <= run_color_in;
         group_open_ff <= group_open_in; ref_ff <= ref_in;
         sr_ff <= sr_in; sg_ff <= sg_in; sb_ff <= sb_in; cnt_ff <= cnt_in;
         pend_ff <= pend_in;
      end
      pend_data_ff <= pend_data_in;
   end
endmodule

FILE: rtl/lrle_queue.sv
`timescale 1ns / 1ps
module lrle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lrle_pkg::group_type push_data,
   output logic                room2,
   output logic                pop_valid,
   input  logic                pop,
   output lrle_pkg::group_type pop_data
);
   import lrle_pkg::*;

   localparam int Depth = 4;
   group_type  mem_ff [Depth];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] n_ff;

   assign room2     = n_ff <= 3'(Depth - 2);
   assign pop_valid = n_ff != '0;
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; n_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         n_ff <= n_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

FILE: rtl/lrle_back.sv
`timescale 1ns / 1ps
module lrle_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  lrle_pkg::group_type q_data,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [24:0]         run_length,
   output logic [7:0]          avg_red,
   output logic [7:0]          avg_green,
   output logic [7:0]          avg_blue,
   output logic                last_run
);
   import lrle_pkg::*;

   // Three restoring dividers share one bit-serial step counter.
   div_state_type         st_ff, st_in;
   logic [5:0]            step_ff, step_in;
   logic [CountWidth-1:0] den_ff;
   logic                  last_ff;
   logic [SumWidth-1:0]   qr_ff, qg_ff, qb_ff;
   logic [CountWidth:0]   rr_ff, rg_ff, rb_ff;
   logic                  load, run;

   function automatic logic [CountWidth:0] rem_next(input logic [CountWidth:0] r,
         input logic b, input logic [CountWidth-1:0] d);
      logic [CountWidth+1:0] t;
      t = {r, b};
      if (t >= {2'b0, d}) t = t - {2'b0, d};
      return t[CountWidth:0];
   endfunction

   function automatic logic qbit(input logic [CountWidth:0] r, input logic b,
                                 input logic [CountWidth-1:0] d);
      return {r, b} >= {2'b0, d};
   endfunction

   always_comb begin
      st_in = st_ff; step_in = step_ff;
      case (st_ff)
         DIV_IDLE: if (q_valid) begin st_in = DIV_RUN; step_in = '0; end
         DIV_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(SumWidth - 1)) st_in = DIV_DONE;
         end
         DIV_DONE: if (!out_stall) st_in = DIV_IDLE;
         default: st_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      load = 1'b0; run = 1'b0; out_valid = 1'b0;
      case (st_ff)
         DIV_IDLE: load = q_valid;
         DIV_RUN:  run = 1'b1;
         DIV_DONE: out_valid = 1'b1;
         default: ;
      endcase
   end
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= DIV_IDLE; step_ff <= '0;
      end else begin
         st_ff <= st_in; step_ff <= step_in;
      end
      if (load) begin
         den_ff <= (q_data.count == '0) ? CountWidth'(1) : q_data.count;
         last_ff <= q_data.last;
         qr_ff <= q_data.sum_red; qg_ff <= q_data.sum_green;
         qb_ff <= q_data.sum_blue;
         rr_ff <= '0; rg_ff <= '0; rb_ff <= '0;
         run_length <= q_data.count;
      end else if (run) begin
         rr_ff <= rem_next(rr_ff, qr_ff[SumWidth-1], den_ff);
         rg_ff <= rem_next(rg_ff, qg_ff[SumWidth-1], den_ff);
         rb_ff <= rem_next(rb_ff, qb_ff[SumWidth-1], den_ff);
         qr_ff <= {qr_ff[SumWidth-2:0], qbit(rr_ff, qr_ff[SumWidth-1], den_ff)};
         qg_ff <= {qg_ff[SumWidth-2:0], qbit(rg_ff, qg_ff[SumWidth-1], den_ff)};
         qb_ff <= {qb_ff[SumWidth-2:0], qbit(rb_ff, qb_ff[SumWidth-1], den_ff)};
      end
   end

   assign avg_red   = qr_ff[7:0];
   assign avg_green = qg_ff[7:0];
   assign avg_blue  = qb_ff[7:0];
   assign last_run  = last_ff;
endmodule

FILE: rtl/lossy_rgb_run_length_encoder_top.sv
`timescale 1ns / 1ps
// Lossy RGB run-length encoder.
// Input channel req_*: one pixel per transfer, req_last_pixel ends a frame.
// Result channel rsp_*: one merged group per transfer (count, averages, last flag).
// csr_write/csr_wdata set the merge tolerance; write only while idle.
// The front end takes one pixel per cycle while the group queue has room for two
// entries; a pixel that closes a group and also ends the frame holds req_stall
// one extra cycle. Groups wait in a four-entry queue.
// The back end divides the three channel sums by the count bit-serially; it
// loads a group from the queue head, divides it and holds the result until it
// is taken, and loads no new group before that.
// Reset clears runs, group, queue and tolerance (0). While rsp_stall is high the
// result holds, the queue fills, and then req_stall rises.
module lossy_rgb_run_length_encoder_top #(
   parameter int MAX_FRAME_PIXELS = 16777216
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_run_length,
   output logic [7:0]  rsp_avg_red,
   output logic [7:0]  rsp_avg_green,
   output logic [7:0]  rsp_avg_blue,
   output logic        rsp_last_run
);
   import lrle_pkg::*;

   logic [7:0] tol_ff;
   logic       push, room2, qv, pop;
   group_type  pdata, qdata;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= '0;
      else if (csr_write) tol_ff <= csr_wdata;
   end

   lrle_front #(.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)) u_front (
      .clock, .reset, .tolerance(tol_ff), .in_valid(req_valid), .in_stall(req_stall),
      .red(req_red), .green(req_green), .blue(req_blue), .last_pixel(req_last_pixel),
      .q_push(push), .q_data(pdata), .q_room2(room2));

   lrle_queue u_queue (.clock, .reset, .push, .push_data(pdata), .room2,
      .pop_valid(qv), .pop, .pop_data(qdata));

   lrle_back u_back (.clock, .reset, .q_valid(qv), .q_pop(pop), .q_data(qdata),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .run_length(rsp_run_length),
      .avg_red(rsp_avg_red), .avg_green(rsp_avg_green), .avg_blue(rsp_avg_blue),
      .last_run(rsp_last_run));
endmodule

FILE: rtl/lrle_checker.sv
`timescale 1ns / 1ps
module lrle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [24:0] rsp_run_length,
   input logic        rsp_last_run
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_length) &&
                                 $stable(rsp_last_run))
      else $error("stalled result changed");
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length != 25'd0)
      else $error("empty group");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("results back to back");
endmodule

bind lossy_rgb_run_length_encoder_top lrle_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_run_length, .rsp_last_run);
